// ===== hw/rtl/plep_pkg.sv =====
// Package: shared types, constants and codes of the eviction planner.
package plep_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  // Resident totals: sixteen 40-bit sizes fit in 44 bits, with room to spare.
  localparam int TOT_W = 48;

  typedef enum logic [1:0] {
    KIND_REG     = 2'd0,
    KIND_USE     = 2'd1,
    KIND_EVICT   = 2'd2,
    KIND_PRELOAD = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_EV_START,
    ST_SCAN,
    ST_PICK,
    ST_EMPTY,
    ST_PRE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_index;
    logic [39:0] size_bytes;
    logic [15:0] prio;
    logic        is_resident;
    logic [47:0] timestamp;
    logic [43:0] budget;
    logic        first_in_list;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_slot;
    logic       named;
    logic       last_of_run;
  } out_item_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic        loaded;
    logic [47:0] last_use;
    logic [15:0] prio;
    logic [39:0] size;
  } slot_t;

endpackage

// ===== hw/rtl/plep_if.sv =====
// Interfaces: valid/ready channels for request and result words.
interface plep_in_if;
  import plep_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plep_out_if;
  import plep_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/plep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/priority_lru_eviction_planner.sv =====
// Slot table with priority-then-LRU eviction plans and preload runs. Slot
// fields live in one synchronous RAM; valid marks and the resident total sit
// in flops, the total kept current by a read-modify-write on every in-range
// register item. Register and use items read their slot on acceptance and
// write it back in ST_RMW. An eviction plan makes one full RAM sweep per
// named slot (one per minimum search), or gives the empty marker when the
// total already fits. Preload and eviction results wait out output stalls.
// One item is in work at a time. No clearing pass is needed after reset.
module priority_lru_eviction_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  plep_in_if.sink     in_i,
  plep_out_if.source  out_o
);
  import plep_pkg::*;

  state_e               state_q, state_d;
  in_item_t             item_q, item_d;
  logic [SLOTS-1:0]     valid_q, valid_d;
  logic [SLOTS-1:0]     taken_q, taken_d;
  logic [TOT_W-1:0]     res_total_q, res_total_d;
  logic [TOT_W-1:0]     ev_tot_q, ev_tot_d;
  logic [TOT_W-1:0]     run_q, run_d;
  logic                 stopped_q, stopped_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [15:0]          best_prio_q, best_prio_d;
  logic [47:0]          best_ts_q, best_ts_d;
  logic [39:0]          best_size_q, best_size_d;
  logic                 found_q, found_d;
  logic                 ovld_q, ovld_d;
  out_item_t            obuf_q, obuf_d;

  logic                 accept, can_load;
  logic                 mem_we;
  logic [IDX_W-1:0]     raddr, item_idx, scan_idx;
  slot_t                rd, wdata;
  logic                 in_range, scan_end;
  logic [TOT_W-1:0]     budget_ext, ev_after, old_part, new_part;
  logic [TOT_W:0]       pre_sum;
  logic                 pre_ok, pre_over, ev_fits, pick_last;

  plep_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (item_idx),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign accept     = in_i.valid && in_i.ready;
  assign can_load   = !ovld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = ovld_q;
  assign out_o.data  = obuf_q;

  assign item_idx   = IDX_W'(item_q.slot_index);
  assign in_range   = (32'(item_q.slot_index) < SLOTS);
  assign scan_idx   = IDX_W'(cnt_q - CNT_W'(1));
  assign scan_end   = (cnt_q == CNT_W'(SLOTS));
  assign budget_ext = TOT_W'(item_q.budget);
  assign ev_fits    = (res_total_q <= budget_ext);
  assign ev_after   = ev_tot_q - TOT_W'(best_size_q);
  assign pick_last  = (ev_after <= budget_ext);
  assign pre_sum    = (TOT_W+1)'(run_q) + (TOT_W+1)'(rd.size);
  assign pre_ok     = !stopped_q && in_range && valid_q[item_idx] && !rd.loaded;
  assign pre_over   = (pre_sum > (TOT_W+1)'(item_q.budget));
  assign old_part   = (valid_q[item_idx] && rd.loaded) ? TOT_W'(rd.size) : '0;
  assign new_part   = item_q.is_resident ? TOT_W'(item_q.size_bytes) : '0;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority case (in_i.data.kind)
            KIND_EVICT:   state_d = ST_EV_START;
            KIND_PRELOAD: state_d = ST_PRE;
            default:      state_d = (32'(in_i.data.slot_index) < SLOTS) ? ST_RMW : ST_IDLE;
          endcase
        end
      end
      ST_RMW:      state_d = ST_IDLE;
      ST_EV_START: state_d = ev_fits ? ST_EMPTY : ST_SCAN;
      ST_SCAN:     state_d = scan_end ? ST_PICK : ST_SCAN;
      ST_PICK: begin
        if (can_load) state_d = pick_last ? ST_IDLE : ST_SCAN;
      end
      ST_EMPTY: begin
        if (can_load) state_d = ST_IDLE;
      end
      ST_PRE: begin
        if (!pre_ok || pre_over || can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_d      = item_q;
    valid_d     = valid_q;
    taken_d     = taken_q;
    res_total_d = res_total_q;
    ev_tot_d    = ev_tot_q;
    run_d       = run_q;
    stopped_d   = stopped_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    best_ts_d   = best_ts_q;
    best_size_d = best_size_q;
    found_d     = found_q;
    ovld_d      = ovld_q && !out_o.ready;
    obuf_d      = obuf_q;
    mem_we      = 1'b0;
    wdata       = rd;
    raddr       = item_idx;
    unique case (state_q)
      ST_IDLE: begin
        raddr = IDX_W'(in_i.data.slot_index);
        if (accept) begin
          item_d = in_i.data;
          if (in_i.data.kind == KIND_PRELOAD && in_i.data.first_in_list) begin
            run_d     = res_total_q;
            stopped_d = 1'b0;
          end
        end
      end
      ST_RMW: begin
        if (item_q.kind == KIND_REG) begin
          mem_we            = 1'b1;
          wdata             = {item_q.is_resident, item_q.timestamp, item_q.prio,
                               item_q.size_bytes};
          valid_d[item_idx] = 1'b1;
          res_total_d       = res_total_q - old_part + new_part;
        end else if (valid_q[item_idx]) begin
          mem_we        = 1'b1;
          wdata.last_use = item_q.timestamp;
        end
      end
      ST_EV_START: begin
        taken_d  = '0;
        ev_tot_d = res_total_q;
        cnt_d    = '0;
        found_d  = 1'b0;
      end
      ST_SCAN: begin
        raddr = cnt_q[IDX_W-1:0];
        if (!scan_end) cnt_d = cnt_q + CNT_W'(1);
        // data in rd belongs to the previous read address
        if (cnt_q != '0 && valid_q[scan_idx] && rd.loaded && !taken_q[scan_idx] &&
            (!found_q || rd.prio < best_prio_q ||
             (rd.prio == best_prio_q && rd.last_use < best_ts_q))) begin
          found_d     = 1'b1;
          best_idx_d  = scan_idx;
          best_prio_d = rd.prio;
          best_ts_d   = rd.last_use;
          best_size_d = rd.size;
        end
      end
      ST_PICK: begin
        if (can_load) begin
          ovld_d              = 1'b1;
          obuf_d              = '{chosen_slot: 4'(best_idx_q), named: 1'b1,
                                  last_of_run: pick_last};
          taken_d[best_idx_q] = 1'b1;
          ev_tot_d            = ev_after;
          cnt_d               = '0;
          found_d             = 1'b0;
        end
      end
      ST_EMPTY: begin
        if (can_load) begin
          ovld_d = 1'b1;
          obuf_d = '{chosen_slot: 4'd0, named: 1'b0, last_of_run: 1'b1};
        end
      end
      ST_PRE: begin
        if (pre_ok && pre_over) begin
          stopped_d = 1'b1;
        end else if (pre_ok && can_load) begin
          run_d  = pre_sum[TOT_W-1:0];
          ovld_d = 1'b1;
          obuf_d = '{chosen_slot: item_q.slot_index, named: 1'b1, last_of_run: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      taken_q     <= '0;
      res_total_q <= '0;
      run_q       <= '0;
      stopped_q   <= 1'b0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      ovld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      taken_q     <= taken_d;
      res_total_q <= res_total_d;
      run_q       <= run_d;
      stopped_q   <= stopped_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      ovld_q      <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    ev_tot_q    <= ev_tot_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_ts_q   <= best_ts_d;
    best_size_q <= best_size_d;
    obuf_q      <= obuf_d;
  end

  // a pick always has a candidate: the remaining total is made of untaken slots
  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PICK |-> found_q)
    else $error("eviction pick without candidate");

  a_ev_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> ev_tot_q <= res_total_q)
    else $error("eviction total above resident total");

  a_rmw_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RMW |=> state_q == ST_IDLE)
    else $error("table update took more than one write cycle");

endmodule
